FILE: src/lcas_pkg.sv
// ============================================================================
// lcas_pkg: shared types and constants of the load-cell averaging weigher
// Register map, sequencer states, divider handshake structs and the fixed
// field widths used by the top level and the shared divider.
// ============================================================================
package lcas_pkg;

   // Defaults of the top-level parameters.
   localparam int BLOCK_SAMPLES_DEF = 16;
   localparam int CODE_BITS_DEF     = 24;

   // Fixed field widths.
   localparam int OFS_W      = 24;
   localparam int TARE_W     = 32;
   localparam int SCALE_W    = 32;
   localparam int AVG_OUT_W  = 24;
   localparam int WEIGHT_W   = 32;

   // Register reset values.
   localparam logic [OFS_W-1:0]          ZERO_OFFSET_RST = 24'd8263850;
   localparam logic signed [TARE_W-1:0]  TARE_RST        = 32'sd0;
   localparam logic [SCALE_W-1:0]        SCALE_RST       = 32'd65536;

   // Divisor of the averaged code difference.
   localparam int QUOT_DIV = 100;

   // 1310720 = 2^20 + 2^18 and 20 = 2^4 + 2^2, built from shifts and adds.
   localparam int MUL_SH_HI = 20;
   localparam int MUL_SH_LO = 18;
   localparam int DEN_SH_HI = 4;
   localparam int DEN_SH_LO = 2;

   // Width of the weight denominator (20 * scale).
   localparam int DEN_W = SCALE_W + 5;

   // Default dividend width of the shared divider.
   localparam int DIV_DVD_W_DEF = 56;

   // Saturation limits of the weight.
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

   // Register file port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_ZERO_OFFSET = 2'd0,
      REG_TARE        = 2'd1,
      REG_SCALE       = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_AVG,
      ST_DIFF,
      ST_QDIV,
      ST_TARE,
      ST_NUM,
      ST_WSTART,
      ST_WDIV,
      ST_WB
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: src/load_cell_average_scale_top.sv
// ============================================================================
// load_cell_average_scale_top: block-averaging load-cell weigher
// Sums blocks of converter samples, averages them, removes the zero offset,
// divides by one hundred, removes the tare and divides by the Q16.16 scale
// with a rounding bias of 0.05, giving one saturated weight per block.
// ============================================================================
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_raw_code
//   rsp      out        rsp_valid/rsp_stall   rsp_weight, rsp_average_code
//   csr      in/out     csr_psel/csr_penable  csr_paddr, csr_pwdata, csr_prdata
//
// A sample that does not close a block is taken in the cycle it arrives, and
// the block keeps taking samples while an earlier weight waits on rsp. The
// sample that closes a block starts the block's work (a 55-bit dividend at
// the default sizes), during which req_stall stays high: a state each for
// the average, the zero offset, the division by one hundred, the tare, the
// numerator and the divider start, the shared bit-per-cycle divider lcas_div
// for the weight, and a state to load the output register. The average and
// the division by one hundred are multiplications by constant reciprocals
// and take one state each.
// Reset is synchronous and active high; it clears the block sum, the sample
// count and the sequencer, and loads the registers with their reset values.
// A finished weight waits in the output register until rsp_stall is low; the
// sequencer holds the next weight back while the previous beat is unaccepted,
// which adds the remaining length of that stall to the block's work.
//
module load_cell_average_scale_top #(
   parameter int BLOCK_SAMPLES = lcas_pkg::BLOCK_SAMPLES_DEF,
   parameter int CODE_BITS     = lcas_pkg::CODE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Sample channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [CODE_BITS-1:0]                   req_raw_code,
   // Result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lcas_pkg::WEIGHT_W-1:0]   rsp_weight,
   output logic [lcas_pkg::AVG_OUT_W-1:0]         rsp_average_code,
   // Register port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lcas_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [lcas_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [lcas_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import lcas_pkg::*;

   // Sample count and block sum widths follow the block length and code size.
   localparam int CNT_W  = $clog2(BLOCK_SAMPLES);
   localparam int SUM_W  = CODE_BITS + CNT_W;
   // Signed difference of the average and the zero offset.
   localparam int DIFF_W = ((CODE_BITS > OFS_W) ? CODE_BITS : OFS_W) + 1;
   // Signed difference after the tare.
   localparam int T_W    = ((DIFF_W > TARE_W) ? DIFF_W : TARE_W) + 1;
   // Signed weight numerator: t * 1310720 + scale.
   localparam int NUM_W  = T_W + MUL_SH_HI + 2;
   // Shared divider operand widths.
   localparam int DV_W   = NUM_W;
   localparam int DVS_W  = DEN_W;

   // Division by one hundred is a multiplication by the rounded-up
   // reciprocal; the extra shift keeps its error below one step for every
   // magnitude of the difference.
   localparam int QDIV_SH = DIFF_W + $clog2(QUOT_DIV);
   localparam int QREC_W  = DIFF_W + 2;
   localparam logic [QREC_W-1:0] QREC =
      QREC_W'(((64'd1 << QDIV_SH) + 64'(QUOT_DIV - 1)) / 64'(QUOT_DIV));
   // The block average works the same way; a power-of-two block length
   // makes the reciprocal a plain power of two, so it is only a shift.
   localparam int AVG_SH  = SUM_W + CNT_W;
   localparam int AREC_W  = SUM_W + 2;
   localparam logic [AREC_W-1:0] AREC =
      AREC_W'(((64'd1 << AVG_SH) + 64'(BLOCK_SAMPLES - 1)) / 64'(BLOCK_SAMPLES));

   localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(BLOCK_SAMPLES - 1);
   localparam logic [CODE_BITS-1:0] CODE_SIGN = {1'b1, {(CODE_BITS-1){1'b0}}};

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type                  state_ff, state_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [SUM_W-1:0]           blk_ff, blk_in;
   logic [CODE_BITS-1:0]       avg_ff, avg_in;
   logic                       neg_ff, neg_in;
   logic [DIFF_W-1:0]          dmag_ff, dmag_in;
   logic signed [DIFF_W-1:0]   q_ff, q_in;
   logic signed [T_W-1:0]      t_ff, t_in;
   logic signed [NUM_W-1:0]    num_ff, num_in;
   logic signed [WEIGHT_W-1:0] wt_ff, wt_in;

   logic                       rsp_valid_ff;
   logic signed [WEIGHT_W-1:0] rsp_weight_ff;
   logic [AVG_OUT_W-1:0]       rsp_avg_ff;

   logic [OFS_W-1:0]           zero_offset_ff;
   logic signed [TARE_W-1:0]   tare_ff;
   logic [SCALE_W-1:0]         scale_ff;

   // ------------------------------------------------------------------------
   // Shared divider
   // ------------------------------------------------------------------------
   div_ctrl_type               div_ctrl;
   div_stat_type               div_stat;
   logic [DV_W-1:0]            div_dividend;
   logic [DVS_W-1:0]           div_divisor;
   logic [DV_W-1:0]            div_quot;

   lcas_div #(
      .DVD_W (DV_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // ------------------------------------------------------------------------
   // Datapath helpers
   // ------------------------------------------------------------------------
   logic [CODE_BITS-1:0]       code;
   logic [SUM_W-1:0]           sum_next;
   logic [SUM_W+AREC_W-1:0]    avg_prod;
   logic [CODE_BITS-1:0]       avg_calc;
   logic signed [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]          diff_mag;
   logic [DIFF_W+QREC_W-1:0]   q_prod;
   logic [DIFF_W-1:0]          q_mag;
   logic [SCALE_W-1:0]         sc_eff;
   logic signed [NUM_W-1:0]    num_t;
   logic signed [NUM_W-1:0]    num_calc;
   logic [NUM_W-1:0]           num_mag;
   logic [DVS_W-1:0]           den;
   logic                       pos_ovf;
   logic                       neg_ovf;
   logic [AVG_OUT_W-1:0]       avg_out;
   logic [CODE_BITS+AVG_OUT_W-1:0] avg_wide;
   logic                       rsp_load;

   // Flipping the top bit turns the two's complement sample into offset binary.
   assign code     = req_raw_code ^ CODE_SIGN;
   assign sum_next = sum_ff + SUM_W'(code);

   assign avg_prod = blk_ff * AREC;
   assign avg_calc = CODE_BITS'(avg_prod >> AVG_SH);

   assign diff     = signed'(DIFF_W'(avg_ff)) - signed'(DIFF_W'(zero_offset_ff));
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign q_prod   = dmag_ff * QREC;
   assign q_mag    = DIFF_W'(q_prod >> QDIV_SH);

   // A zero scale behaves as the smallest nonzero scale.
   assign sc_eff   = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;
   assign num_t    = NUM_W'(t_ff);
   assign num_calc = (num_t <<< MUL_SH_HI) + (num_t <<< MUL_SH_LO)
                   + signed'(NUM_W'(sc_eff));
   assign num_mag  = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign den      = (DVS_W'(sc_eff) << DEN_SH_HI) + (DVS_W'(sc_eff) << DEN_SH_LO);

   // Quotient magnitude beyond the signed 32-bit range saturates.
   assign pos_ovf  = (div_quot[DV_W-1:WEIGHT_W-1] != '0);
   assign neg_ovf  = (div_quot[DV_W-1:WEIGHT_W] != '0)
                   || (div_quot[WEIGHT_W-1] && (div_quot[WEIGHT_W-2:0] != '0));

   assign avg_wide = {{AVG_OUT_W{1'b0}}, avg_ff};
   assign avg_out  = avg_wide[AVG_OUT_W-1:0];

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      avg_ff  <= avg_in;
      neg_ff  <= neg_in;
      dmag_ff <= dmag_in;
      q_ff    <= q_in;
      t_ff    <= t_in;
      num_ff  <= num_in;
      wt_ff   <= wt_in;
   end

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      blk_in        = blk_ff;
      avg_in        = avg_ff;
      neg_in        = neg_ff;
      dmag_in       = dmag_ff;
      q_in          = q_ff;
      t_in          = t_ff;
      num_in        = num_ff;
      wt_in         = wt_ff;
      div_ctrl      = '0;
      div_dividend  = '0;
      div_divisor   = '0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         ST_COLLECT: begin
            // req_stall is low here, so a valid sample is taken this cycle.
            if (req_valid) begin
               if (count_ff == CNT_LAST) begin
                  sum_in   = '0;
                  count_in = '0;
                  blk_in   = sum_next;
                  state_in = ST_AVG;
               end else begin
                  sum_in   = sum_next;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_AVG: begin
            avg_in   = avg_calc;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // Divide the magnitude and restore the sign: truncation to zero.
            neg_in   = diff[DIFF_W-1];
            dmag_in  = diff_mag;
            state_in = ST_QDIV;
         end
         ST_QDIV: begin
            q_in     = neg_ff ? -signed'(q_mag) : signed'(q_mag);
            state_in = ST_TARE;
         end
         ST_TARE: begin
            t_in     = T_W'(q_ff) - T_W'(tare_ff);
            state_in = ST_NUM;
         end
         ST_NUM: begin
            num_in   = num_calc;
            state_in = ST_WSTART;
         end
         ST_WSTART: begin
            neg_in         = num_ff[NUM_W-1];
            div_ctrl.start = 1'b1;
            div_dividend   = DV_W'(num_mag);
            div_divisor    = den;
            state_in       = ST_WDIV;
         end
         ST_WDIV: begin
            if (div_stat.done) begin
               if (neg_ff) begin
                  wt_in = neg_ovf ? WEIGHT_MIN : -signed'(div_quot[WEIGHT_W-1:0]);
               end else begin
                  wt_in = pos_ovf ? WEIGHT_MAX : signed'(div_quot[WEIGHT_W-1:0]);
               end
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_COLLECT);

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_weight_ff <= wt_ff;
         rsp_avg_ff    <= avg_out;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_weight       = rsp_weight_ff;
   assign rsp_average_code = rsp_avg_ff;

   // ------------------------------------------------------------------------
   // Register port: index in address bits [3:2], low byte bits ignored.
   // ------------------------------------------------------------------------
   logic          csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= ZERO_OFFSET_RST;
         tare_ff        <= TARE_RST;
         scale_ff       <= SCALE_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ZERO_OFFSET: zero_offset_ff <= csr_pwdata[OFS_W-1:0];
            REG_TARE:        tare_ff        <= signed'(csr_pwdata[TARE_W-1:0]);
            REG_SCALE:       scale_ff       <= csr_pwdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ZERO_OFFSET: csr_prdata = CSR_DATA_W'(zero_offset_ff);
         REG_TARE:        csr_prdata = CSR_DATA_W'(unsigned'(tare_ff));
         REG_SCALE:       csr_prdata = CSR_DATA_W'(scale_ff);
         default:         csr_prdata = '0;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while still busy");

   a_empty_block: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0))
      else $error("block sum not clear at the start of a block");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_WB))
      else $error("new weight loaded over an unaccepted beat");

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_WDIV))
      else $error("divider finished while the sequencer was not waiting");
`endif

endmodule

FILE: src/lcas_div.sv
// ============================================================================
// lcas_div: shared restoring divider
// Unsigned divider that resolves one quotient bit per cycle. Operands are
// captured on start; done pulses for one cycle with the quotient valid.
// ============================================================================
module lcas_div #(
   parameter int DVD_W = lcas_pkg::DIV_DVD_W_DEF,
   parameter int DVS_W = lcas_pkg::DEN_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lcas_pkg::div_ctrl_type    ctrl,
   input  logic [DVD_W-1:0]          dividend,
   input  logic [DVS_W-1:0]          divisor,
   output lcas_pkg::div_stat_type    stat,
   output logic [DVD_W-1:0]          quotient
);
   import lcas_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DVD_W-1:0]  acc_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;

   logic [DVS_W:0]    shifted;
   logic              ge;
   logic [DVS_W:0]    sub;

   // The dividend shifts out of the top of acc_ff while quotient bits enter
   // at the bottom.
   assign shifted = {rem_ff, acc_ff[DVD_W-1]};
   assign ge      = (shifted >= {1'b0, dvs_ff});
   assign sub     = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_LAST;
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         acc_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         acc_ff <= {acc_ff[DVD_W-2:0], ge};
         rem_ff <= ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = acc_ff;

`ifndef NO_ASSERTIONS
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctrl.start && cnt_ff == '0) |=> done_ff)
      else $error("divider missed done after its last step");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> busy_ff)
      else $error("divider did not go busy after start");
`endif

endmodule
